// ===== src/plti_pkg.sv =====
// Package for the piecewise-linear table interpolator.
// Payload structs, operation and status codes, sequencer states, widths.
// No dependencies.
package plti_pkg;

  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;
  localparam int MAG_W      = VALUE_BITS + 1;
  localparam int NUM_W      = 2 * VALUE_BITS + 1;
  localparam int SUM_W      = NUM_W + 2;
  localparam int ITER_W     = 7;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_FORWARD = 2'd1,
    OP_INVERSE = 2'd2,
    OP_SLOPE   = 2'd3
  } plti_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EQ_X  = 2'd1,
    ST_BELOW = 2'd2
  } plti_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_RD_FIRST,
    S_CHECK,
    S_BIS_RD,
    S_BIS_CMP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } plti_state_t;

  typedef struct packed {
    logic [1:0]                    operation;
    logic [IDX_W-1:0]              point_index;
    logic signed [VALUE_BITS-1:0]  point_x;
    logic signed [VALUE_BITS-1:0]  point_y;
    logic signed [VALUE_BITS-1:0]  query_value;
  } plti_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  result_value;
    logic [1:0]                    status;
  } plti_out_t;

endpackage

// ===== src/plti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/piecewise_linear_table_interp.sv =====
// Piecewise-linear breakpoint table with forward, inverse and slope queries.
// Depends on plti_pkg and plti_ram (one RAM holds x and y of each breakpoint).
//
//   channel   ports                          handshake
//   input     start, busy, in_item           beat when start && !busy
//   result    out_valid, out_item            one-cycle strobe, no backpressure
//   config    cfg_valid, cfg_ready, cfg_data beat when cfg_valid && cfg_ready
//
// A write is acknowledged by the result strobe. A query reads the table through
// the single RAM read port, one entry at a time: forward bisection needs up to
// log2(points) reads, the inverse scan up to points-1 reads. Interpolation then
// runs a 33-step shift-add multiply and a 65-step restoring divide on one shared
// adder.
// Reset (synchronous, rst_n low) clears the sequencer and sets point_count to 2.
module piecewise_linear_table_interp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  plti_pkg::plti_in_t     in_item,
  output logic                   out_valid,
  output plti_pkg::plti_out_t    out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [6:0]             cfg_data
);
  import plti_pkg::*;

  plti_state_t state_r, state_nxt;

  logic [CNT_W-1:0]             point_count_r;
  logic [IDX_W-1:0]             last_r, lo_r, hi_r, k_r;
  logic [1:0]                   op_r;
  logic signed [VALUE_BITS-1:0] q_r, ax_r, ay_r, bx_r, by_r, base_r, res_r;
  logic [1:0]                   status_r;
  logic                         neg_r;
  logic [NUM_W-1:0]             num_r;
  logic [MAG_W-1:0]             m1_r, mplr_r, div_r, rem_r;
  logic [ITER_W-1:0]            cnt_r;

  logic                         accept;
  logic [IDX_W-1:0]             rd_addr, last_c, mid, lo_n, hi_n;
  logic [2*VALUE_BITS-1:0]      rd_data;
  logic signed [VALUE_BITS-1:0] ex, ey;
  logic                         bis_go_hi, bis_more, scan_stop;
  logic signed [MAG_W-1:0]      dx_s, dy_s, dq_s;
  logic [MAG_W-1:0]             dx_m, dy_m, dq_m;

  // shared adder
  logic [NUM_W-1:0]             add_a, add_b;
  logic                         add_cin;
  logic [NUM_W:0]               add_sum;
  logic [MAG_W:0]               rem_sh;
  logic                         div_ge;
  logic signed [SUM_W-1:0]      fin_sum, q_ext;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (point_count_r < CNT_W'(2)) begin
      last_c = IDX_W'(1);
    end else if (point_count_r > CNT_W'(MAX_POINTS)) begin
      last_c = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_c = IDX_W'(point_count_r - CNT_W'(1));
    end
  end

  plti_ram #(.WIDTH(2 * VALUE_BITS), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (accept && (in_item.operation == OP_WRITE)),
    .waddr (in_item.point_index),
    .wdata ({in_item.point_x, in_item.point_y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign ex = $signed(rd_data[2*VALUE_BITS-1:VALUE_BITS]);
  assign ey = $signed(rd_data[VALUE_BITS-1:0]);

  assign mid       = IDX_W'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign bis_go_hi = ex > q_r;
  assign lo_n      = bis_go_hi ? lo_r : mid;
  assign hi_n      = bis_go_hi ? mid : hi_r;
  assign bis_more  = {1'b0, hi_n} > ({1'b0, lo_n} + (IDX_W+1)'(1));
  assign scan_stop = (q_r <= ey) || (k_r == last_r);

  // segment differences, valid in S_SETUP
  assign dx_s = MAG_W'(bx_r) - MAG_W'(ax_r);
  assign dy_s = MAG_W'(by_r) - MAG_W'(ay_r);
  assign dq_s = MAG_W'(q_r) - ((op_r == OP_FORWARD) ? MAG_W'(ax_r) : MAG_W'(ay_r));
  assign dx_m = dx_s[MAG_W-1] ? MAG_W'(-dx_s) : MAG_W'(dx_s);
  assign dy_m = dy_s[MAG_W-1] ? MAG_W'(-dy_s) : MAG_W'(dy_s);
  assign dq_m = dq_s[MAG_W-1] ? MAG_W'(-dq_s) : MAG_W'(dq_s);

  // one adder serves the multiply (accumulate) and the divide (trial subtract)
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  always_comb begin
    if (state_r == S_MUL) begin
      add_a   = {num_r[NUM_W-2:0], 1'b0};
      add_b   = mplr_r[MAG_W-1] ? NUM_W'(m1_r) : '0;
      add_cin = 1'b0;
    end else begin
      add_a   = NUM_W'(rem_sh);
      add_b   = ~NUM_W'(div_r);
      add_cin = 1'b1;
    end
  end
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (NUM_W+1)'(add_cin);
  assign div_ge  = add_sum[NUM_W];

  assign q_ext   = neg_r ? -$signed({2'b00, num_r}) : $signed({2'b00, num_r});
  assign fin_sum = SUM_W'(base_r) + q_ext;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.operation == OP_WRITE) ? S_DONE : S_RD_LAST;
        end
      end
      S_RD_LAST:  state_nxt = S_RD_FIRST;
      S_RD_FIRST: state_nxt = S_CHECK;
      S_CHECK: begin
        if (op_r == OP_FORWARD) begin
          if (q_r > bx_r || q_r < ex) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = (last_r > IDX_W'(1)) ? S_BIS_RD : S_SETUP;
          end
        end else begin
          state_nxt = (q_r < ey || q_r > by_r) ? S_DONE : S_SCAN_RD;
        end
      end
      S_BIS_RD:   state_nxt = S_BIS_CMP;
      S_BIS_CMP:  state_nxt = bis_more ? S_BIS_RD : S_SETUP;
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = scan_stop ? S_SETUP : S_SCAN_RD;
      S_SETUP: begin
        unique case (op_r)
          OP_FORWARD: state_nxt = (dx_m == '0) ? S_DONE : S_MUL;
          OP_INVERSE: state_nxt = (q_r == by_r || dy_m == '0) ? S_DONE : S_MUL;
          default:    state_nxt = (dy_m == '0) ? S_DONE : S_DIV;
        endcase
      end
      S_MUL:  state_nxt = (cnt_r == ITER_W'(1)) ? S_DIV : S_MUL;
      S_DIV:  state_nxt = (cnt_r == ITER_W'(1)) ? S_FIN : S_DIV;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    unique case (state_r)
      S_RD_LAST: rd_addr = last_r;
      S_BIS_RD:  rd_addr = mid;
      S_SCAN_RD: rd_addr = k_r;
      default:   rd_addr = '0;
    endcase
  end

  assign out_item.result_value = res_r;
  assign out_item.status       = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= CNT_W'(2);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        point_count_r <= cfg_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r     <= in_item.operation;
        q_r      <= in_item.query_value;
        last_r   <= last_c;
        res_r    <= '0;
        status_r <= ST_OK;
      end
      S_RD_FIRST: begin
        bx_r <= ex;
        by_r <= ey;
      end
      S_CHECK: begin
        ax_r <= ex;
        ay_r <= ey;
        lo_r <= '0;
        hi_r <= last_r;
        k_r  <= IDX_W'(1);
        if (op_r == OP_FORWARD) begin
          if (q_r > bx_r) begin
            res_r <= by_r;
          end else if (q_r < ex) begin
            res_r <= ey;
          end
        end else if (q_r < ey) begin
          status_r <= ST_BELOW;
        end else if (q_r > by_r) begin
          res_r <= bx_r;
        end
      end
      S_BIS_CMP: begin
        lo_r <= lo_n;
        hi_r <= hi_n;
        if (bis_go_hi) begin
          bx_r <= ex;
          by_r <= ey;
        end else begin
          ax_r <= ex;
          ay_r <= ey;
        end
      end
      S_SCAN_CMP: begin
        if (scan_stop) begin
          bx_r <= ex;
          by_r <= ey;
        end else begin
          ax_r <= ex;
          ay_r <= ey;
          k_r  <= k_r + IDX_W'(1);
        end
      end
      S_SETUP: begin
        rem_r <= '0;
        num_r <= '0;
        cnt_r <= ITER_W'(MAG_W);
        unique case (op_r)
          OP_FORWARD: begin
            base_r <= ay_r;
            m1_r   <= dq_m;
            mplr_r <= dy_m;
            div_r  <= dx_m;
            neg_r  <= dq_s[MAG_W-1] ^ dy_s[MAG_W-1] ^ dx_s[MAG_W-1];
            if (dx_m == '0) begin
              status_r <= ST_EQ_X;
            end
          end
          OP_INVERSE: begin
            base_r <= ax_r;
            m1_r   <= dq_m;
            mplr_r <= dx_m;
            div_r  <= dy_m;
            neg_r  <= dq_s[MAG_W-1] ^ dx_s[MAG_W-1] ^ dy_s[MAG_W-1];
            if (q_r == by_r) begin
              res_r <= bx_r;
            end else if (dy_m == '0) begin
              res_r <= ax_r;
            end
          end
          default: begin
            // slope: numerator is |dx| in fixed point, no multiply
            base_r <= '0;
            num_r  <= NUM_W'(dx_m) << FRAC_BITS;
            div_r  <= dy_m;
            neg_r  <= dx_s[MAG_W-1] ^ dy_s[MAG_W-1];
            cnt_r  <= ITER_W'(NUM_W);
          end
        endcase
      end
      S_MUL: begin
        num_r  <= add_sum[NUM_W-1:0];
        mplr_r <= {mplr_r[MAG_W-2:0], 1'b0};
        cnt_r  <= (cnt_r == ITER_W'(1)) ? ITER_W'(NUM_W) : cnt_r - ITER_W'(1);
      end
      S_DIV: begin
        rem_r <= div_ge ? add_sum[MAG_W-1:0] : rem_sh[MAG_W-1:0];
        num_r <= {num_r[NUM_W-2:0], div_ge};
        cnt_r <= cnt_r - ITER_W'(1);
      end
      S_FIN: begin
        if (fin_sum[SUM_W-1:VALUE_BITS-1] == '0 || fin_sum[SUM_W-1:VALUE_BITS-1] == '1) begin
          res_r <= fin_sum[VALUE_BITS-1:0];
        end else if (fin_sum[SUM_W-1]) begin
          res_r <= {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
          res_r <= {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
      end
      default: begin
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_BELOW) |-> (out_item.result_value == '0))
    else $error("below-table status with nonzero result");

  a_iter_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DIV) |-> (cnt_r != '0))
    else $error("iteration counter ran out");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD) |-> (k_r <= last_r && k_r != '0))
    else $error("inverse scan left the table");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for piecewise_linear_table_interp: loads breakpoint
// tables, runs forward, inverse and slope queries and checks each result.
// Depends on plti_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import plti_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  plti_in_t  in_item;
  logic      out_valid;
  plti_out_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [6:0] cfg_data;

  piecewise_linear_table_interp u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's table, updated at each accepted write beat, and of its point count
  longint    tbl_x [MAX_POINTS];
  longint    tbl_y [MAX_POINTS];
  int        point_count = 2;
  // table as the stimulus plans it (what tbl_* will hold once queued beats land)
  longint    plan_x [MAX_POINTS];
  longint    plan_y [MAX_POINTS];

  plti_in_t  cmd_q[$];
  plti_out_t answer_q[$];
  int        err_cnt = 0;
  int        gap = 0;
  bit        quiet = 1'b0;
  int        op_cnt [4] = '{0, 0, 0, 0};
  int        n_checked = 0;

  task automatic report(input string what);
    $display("ERROR @%0t: %s", $time, what);
    err_cnt++;
  endtask

  function automatic longint unsigned span(input longint a, input longint b,
                                           output bit neg);
    if (a >= b) begin
      neg = 1'b0;
      return a - b;
    end
    neg = 1'b1;
    return b - a;
  endfunction

  // base +/- trunc((m1 * m2 << sh) / d), saturated to 32 bits
  function automatic logic signed [31:0] scaled_ratio(input longint base,
      input longint unsigned m1, input longint unsigned m2, input int sh,
      input longint unsigned d, input bit neg);
    logic [127:0]        p;
    logic signed [131:0] s;
    p = ({64'b0, m1} * {64'b0, m2}) << sh;
    p = p / {64'b0, d};
    if (p[127:64] > 64'd1) p = 128'h1 << 64;
    s = $signed({4'b0, p});
    if (neg) s = -s;
    s = s + base;
    if (s > 132'sd2147483647) return 32'sh7fffffff;
    if (s < -132'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic plti_out_t interp_predict(input plti_in_t it);
    plti_out_t r;
    longint    q;
    int        n, last, lo, hi, mid, k;
    bit        nx, ny, nq, hit;
    longint unsigned dx, dy, dq;
    r.result_value = '0;
    r.status = ST_OK;
    q = longint'($signed(it.query_value));
    n = point_count < 2 ? 2 : (point_count > MAX_POINTS ? MAX_POINTS : point_count);
    last = n - 1;
    case (it.operation)
      OP_WRITE: begin
        tbl_x[it.point_index] = longint'($signed(it.point_x));
        tbl_y[it.point_index] = longint'($signed(it.point_y));
      end
      OP_FORWARD: begin
        if (q > tbl_x[last]) begin
          r.result_value = VALUE_BITS'(tbl_y[last]);
        end else if (q < tbl_x[0]) begin
          r.result_value = VALUE_BITS'(tbl_y[0]);
        end else begin
          lo = 0;
          hi = last;
          while (hi - lo > 1) begin
            mid = (hi + lo) >> 1;
            if (tbl_x[mid] > q) hi = mid;
            else lo = mid;
          end
          dx = span(tbl_x[hi], tbl_x[lo], nx);
          if (dx == 0) begin
            r.status = ST_EQ_X;
          end else begin
            dq = span(q, tbl_x[lo], nq);
            dy = span(tbl_y[hi], tbl_y[lo], ny);
            r.result_value = scaled_ratio(tbl_y[lo], dq, dy, 0, dx, (nq != ny) != nx);
          end
        end
      end
      default: begin
        if (q < tbl_y[0]) begin
          r.status = ST_BELOW;
        end else if (q > tbl_y[last]) begin
          r.result_value = VALUE_BITS'(tbl_x[last]);
        end else begin
          for (k = 1; k < last; k++) begin
            if (q <= tbl_y[k]) break;
          end
          hit = (q == tbl_y[k]);
          dx = span(tbl_x[k], tbl_x[k-1], nx);
          dy = span(tbl_y[k], tbl_y[k-1], ny);
          if (it.operation == OP_INVERSE) begin
            if (hit) begin
              r.result_value = VALUE_BITS'(tbl_x[k]);
            end else if (dy == 0) begin
              r.result_value = VALUE_BITS'(tbl_x[k-1]);
            end else begin
              dq = span(q, tbl_y[k-1], nq);
              r.result_value = scaled_ratio(tbl_x[k-1], dq, dx, 0, dy, (nq != nx) != ny);
            end
          end else if (dy != 0) begin
            r.result_value = scaled_ratio(0, dx, 1, FRAC_BITS, dy, nx != ny);
          end
        end
      end
    endcase
    return r;
  endfunction

  // driver: presents the head of cmd_q, predicts each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        answer_q.push_back(interp_predict(in_item));
        op_cnt[in_item.operation]++;
        void'(cmd_q.pop_front());
        if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
      end
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        start <= 1'b1;
        in_item <= cmd_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        report($sformatf("unexpected result value=%h status=%0d",
                         out_item.result_value, out_item.status));
      end else begin
        if (out_item.result_value !== answer_q[0].result_value)
          report($sformatf("result_value %h, expected %h",
                           out_item.result_value, answer_q[0].result_value));
        if (out_item.status !== answer_q[0].status)
          report($sformatf("status %0d, expected %0d",
                           out_item.status, answer_q[0].status));
        void'(answer_q.pop_front());
        n_checked++;
      end
    end
  end

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic queue_write(input int idx, input longint xv, input longint yv);
    plti_in_t w;
    w.operation   = OP_WRITE;
    w.point_index = IDX_W'(idx);
    w.point_x     = VALUE_BITS'(xv);
    w.point_y     = VALUE_BITS'(yv);
    w.query_value = $urandom;
    plan_x[idx] = xv;
    plan_y[idx] = yv;
    cmd_q.push_back(w);
  endtask

  task automatic queue_query(input plti_op_t op, input longint qv);
    plti_in_t c;
    c.operation   = op;
    c.point_index = IDX_W'($urandom_range(0, MAX_POINTS - 1));
    c.point_x     = $urandom;
    c.point_y     = $urandom;
    c.query_value = VALUE_BITS'(clip32(qv));
    cmd_q.push_back(c);
  endtask

  function automatic longint rand_step();
    if ($urandom_range(0, 7) == 0) return 0;
    return $urandom_range(1, 1 << $urandom_range(2, 26));
  endfunction

  // ascending x with some duplicates; y rising, falling or mixed with flat runs
  task automatic build_table(input int n, input bit extremes);
    longint xv, yv;
    int     ymode;
    ymode = $urandom_range(0, 2);
    xv = extremes ? -64'sd2147483648 : longint'($signed($urandom)) >>> $urandom_range(0, 8);
    yv = extremes ? -64'sd2147483648 : longint'($signed($urandom)) >>> $urandom_range(0, 8);
    if (extremes) ymode = 0;
    for (int i = 0; i < n; i++) begin
      if (extremes && i == n - 1) begin
        xv = 64'sd2147483647;
        yv = 64'sd2147483647;
      end
      queue_write(i, xv, yv);
      xv = clip32(xv + rand_step());
      case (ymode)
        0:       yv = clip32(yv + rand_step());
        1:       yv = clip32(yv - rand_step());
        default: yv = clip32($urandom_range(0, 1) ? yv + rand_step() : yv - rand_step());
      endcase
    end
  endtask

  task automatic queue_random(input int n);
    int       k, sel;
    plti_op_t op;
    longint   base, nxt, qv;
    if ($urandom_range(0, 9) == 0) begin
      queue_write($urandom_range(0, MAX_POINTS - 1), $signed($urandom), $signed($urandom));
      return;
    end
    case ($urandom_range(0, 2))
      0:       op = OP_FORWARD;
      1:       op = OP_INVERSE;
      default: op = OP_SLOPE;
    endcase
    k = $urandom_range(0, n - 1);
    base = (op == OP_FORWARD) ? plan_x[k] : plan_y[k];
    nxt  = (op == OP_FORWARD) ? plan_x[k == n - 1 ? k : k + 1] : plan_y[k == n - 1 ? k : k + 1];
    sel = $urandom_range(0, 3);
    if (sel < 2) qv = base + $urandom_range(0, 4) - 2;
    else if (sel == 2) qv = base + (nxt - base) / longint'($urandom_range(2, 9));
    else qv = $signed($urandom);
    queue_query(op, qv);
  endtask

  task automatic write_count(input int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    point_count = v;
  endtask

  task automatic drain();
    do @(posedge clk); while (cmd_q.size() != 0 || answer_q.size() != 0 || start);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int counts [10] = '{64, 2, 0, 127, 17, 65, 1, 33, 5, 64};
    int n;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 10; p++) begin
      quiet = (p == 9);
      write_count(counts[p]);
      n = counts[p] < 2 ? 2 : (counts[p] > MAX_POINTS ? MAX_POINTS : counts[p]);
      // first table covers every entry so nothing unwritten is ever read
      build_table(p == 0 ? MAX_POINTS : n, p == 0 || p == 3);
      if (p == 0) begin
        queue_query(OP_FORWARD, -64'sd2147483648);
        queue_query(OP_FORWARD, 64'sd2147483647);
        queue_query(OP_FORWARD, plan_x[31]);
        queue_query(OP_FORWARD, plan_x[31] + 1);
        queue_query(OP_FORWARD, plan_x[62] - 1);
        queue_query(OP_INVERSE, -64'sd2147483648);
        queue_query(OP_INVERSE, 64'sd2147483647);
        queue_query(OP_INVERSE, plan_y[10]);
        queue_query(OP_INVERSE, plan_y[10] + 1);
        queue_query(OP_SLOPE, plan_y[10]);
        queue_query(OP_SLOPE, plan_y[0]);
        queue_query(OP_SLOPE, plan_y[40] - 1);
        queue_query(OP_SLOPE, 64'sd2147483647);
        queue_query(OP_SLOPE, -64'sd2147483648);
      end
      for (int i = 0; i < 18; i++) queue_random(n);
      drain();
    end
    repeat (300) @(posedge clk);
    $display("Covered %0d writes, %0d forward, %0d inverse, %0d slope beats; %0d results checked",
             op_cnt[OP_WRITE], op_cnt[OP_FORWARD], op_cnt[OP_INVERSE], op_cnt[OP_SLOPE],
             n_checked);
    $display("Point counts swept from 0 to 127, including clamped settings");
    if (err_cnt == 0 && answer_q.size() == 0) begin
      $display("PASS piecewise_linear_table_interp");
    end else begin
      $display("FAIL piecewise_linear_table_interp");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d results still expected", answer_q.size());
    $display("FAIL piecewise_linear_table_interp");
    $finish;
  end

endmodule
